// File: hw/rtl/fsac_pkg.sv
// fsac_pkg: shared types, constants and character codes for the format
// specifier argument classifier
// no dependencies
package fsac_pkg;

    localparam int MAX_DESCRIPTORS = 64;
    localparam int CNT_MIN_W       = $clog2(MAX_DESCRIPTORS + 1);
    localparam int CNT_W           = (CNT_MIN_W > 7) ? CNT_MIN_W : 7;

    localparam int QUEUE_DEPTH = 4;
    localparam int Q_PTR_W     = $clog2(QUEUE_DEPTH);
    localparam int Q_CNT_W     = $clog2(QUEUE_DEPTH + 1);

    localparam int S_TDATA_W = 8;
    localparam int M_TDATA_W = 24;

    localparam logic [7:0] CH_PERCENT = "%";
    localparam logic [7:0] CH_STAR    = "*";
    localparam logic [7:0] CH_DOT     = ".";
    localparam logic [7:0] CH_H       = "h";
    localparam logic [7:0] CH_L       = "l";
    localparam logic [7:0] CH_J       = "j";
    localparam logic [7:0] CH_Z       = "z";
    localparam logic [7:0] CH_T       = "t";
    localparam logic [7:0] CH_UPPER_L = "L";
    localparam logic [7:0] CH_N       = "n";

    typedef enum logic [3:0] {
        PH_LIT   = 4'd0,
        PH_PCT   = 4'd1,
        PH_FLAGS = 4'd2,
        PH_WDIG  = 4'd3,
        PH_AFTW  = 4'd4,
        PH_DOT   = 4'd5,
        PH_PDIG  = 4'd6,
        PH_LEN   = 4'd7,
        PH_AFTH  = 4'd8,
        PH_AFTL  = 4'd9,
        PH_CONV  = 4'd10
    } phase_t;

    typedef enum logic [3:0] {
        ARG_I32    = 4'd0,
        ARG_U32    = 4'd1,
        ARG_I64    = 4'd2,
        ARG_U64    = 4'd3,
        ARG_DOUBLE = 4'd4,
        ARG_LDBL   = 4'd5,
        ARG_CHAR   = 4'd6,
        ARG_PTR    = 4'd7,
        ARG_STRING = 4'd8
    } arg_t;

    typedef enum logic [3:0] {
        LM_NONE = 4'd0,
        LM_HH   = 4'd1,
        LM_H    = 4'd2,
        LM_L    = 4'd3,
        LM_LL   = 4'd4,
        LM_J    = 4'd5,
        LM_Z    = 4'd6,
        LM_T    = 4'd7,
        LM_BIGL = 4'd8
    } lenmod_t;

    typedef enum logic [1:0] {
        ST_READY    = 2'd0,
        ST_OVERFLOW = 2'd1,
        ST_REJECT   = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        EV_DESC   = 2'd0,
        EV_REJECT = 2'd1,
        EV_FINAL  = 2'd2
    } ev_kind_t;

    typedef struct packed {
        ev_kind_t kind;
        arg_t     arg_type;
        lenmod_t  len_mod;
    } event_t;

endpackage

// File: hw/rtl/fsac_front.sv
// fsac_front: parse phase tracker, turns each accepted character into at
// most one event (descriptor, reject or final); uses fsac_pkg
module fsac_front
    import fsac_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       accept,
    input  logic [7:0] ch,
    input  logic       last,
    output logic       push,
    output event_t     evt
);

    phase_t  phase_reg, phase_next;
    lenmod_t plm_reg, plm_next;
    logic    star_push;
    logic    conv_go;
    lenmod_t conv_lm;

    function automatic logic is_flag(input logic [7:0] c);
        return (c == "-") || (c == "+") || (c == " ") || (c == "#") || (c == "0");
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        return (c >= "0") && (c <= "9");
    endfunction

    // conversion character: known kinds produce a descriptor, n a reject
    function automatic event_t conv_evt(input logic [7:0] c, input lenmod_t lm,
                                        output logic hit);
        event_t e;
        e.kind     = EV_DESC;
        e.arg_type = ARG_I32;
        e.len_mod  = lm;
        hit        = 1'b1;
        case (c) inside
            CH_N: begin
                e.kind = EV_REJECT;
            end
            "f", "F", "e", "E", "g", "G", "a", "A": begin
                e.arg_type = (lm == LM_BIGL) ? ARG_LDBL : ARG_DOUBLE;
            end
            "d", "i": begin
                e.arg_type = (lm <= LM_H) ? ARG_I32 : ARG_I64;
            end
            "u", "x", "X", "o": begin
                e.arg_type = (lm <= LM_H) ? ARG_U32 : ARG_U64;
            end
            "c":     e.arg_type = ARG_CHAR;
            "s":     e.arg_type = ARG_STRING;
            "p":     e.arg_type = ARG_PTR;
            default: hit = 1'b0;
        endcase
        return e;
    endfunction

    always_comb begin
        logic to_flag;
        logic to_dot;
        logic to_len;

        to_flag    = 1'b0;
        to_dot     = 1'b0;
        to_len     = 1'b0;
        conv_go    = 1'b0;
        conv_lm    = LM_NONE;
        star_push  = 1'b0;
        phase_next = phase_reg;
        plm_next   = plm_reg;

        case (phase_reg)
            PH_LIT: begin
                if (ch == CH_PERCENT) phase_next = PH_PCT;
            end
            PH_PCT: begin
                if (ch == CH_PERCENT) phase_next = PH_LIT;
                else                  to_flag = 1'b1;
            end
            PH_FLAGS: to_flag = 1'b1;
            PH_WDIG: begin
                if (!is_digit(ch)) to_dot = 1'b1;
            end
            PH_AFTW: to_dot = 1'b1;
            PH_DOT: begin
                if (ch == CH_STAR) begin
                    phase_next = PH_LEN;
                    star_push  = 1'b1;
                end else if (is_digit(ch)) begin
                    phase_next = PH_PDIG;
                end else begin
                    to_len = 1'b1;
                end
            end
            PH_PDIG: begin
                if (!is_digit(ch)) to_len = 1'b1;
            end
            PH_LEN: to_len = 1'b1;
            PH_AFTH: begin
                if (ch == CH_H) begin
                    plm_next   = LM_HH;
                    phase_next = PH_CONV;
                end else begin
                    conv_go = 1'b1;
                    conv_lm = LM_H;
                end
            end
            PH_AFTL: begin
                if (ch == CH_L) begin
                    plm_next   = LM_LL;
                    phase_next = PH_CONV;
                end else begin
                    conv_go = 1'b1;
                    conv_lm = LM_L;
                end
            end
            PH_CONV: begin
                conv_go = 1'b1;
                conv_lm = plm_reg;
            end
            default: phase_next = PH_LIT;
        endcase

        if (to_flag) begin
            if (is_flag(ch)) begin
                phase_next = PH_FLAGS;
            end else if (ch == CH_STAR) begin
                phase_next = PH_AFTW;
                star_push  = 1'b1;
            end else if (is_digit(ch)) begin
                phase_next = PH_WDIG;
            end else begin
                to_dot = 1'b1;
            end
        end

        if (to_dot) begin
            if (ch == CH_DOT) phase_next = PH_DOT;
            else              to_len = 1'b1;
        end

        if (to_len) begin
            case (ch)
                CH_H: phase_next = PH_AFTH;
                CH_L: phase_next = PH_AFTL;
                CH_J: begin
                    plm_next   = LM_J;
                    phase_next = PH_CONV;
                end
                CH_Z: begin
                    plm_next   = LM_Z;
                    phase_next = PH_CONV;
                end
                CH_T: begin
                    plm_next   = LM_T;
                    phase_next = PH_CONV;
                end
                CH_UPPER_L: begin
                    plm_next   = LM_BIGL;
                    phase_next = PH_CONV;
                end
                default: begin
                    conv_go = 1'b1;
                    conv_lm = LM_NONE;
                end
            endcase
        end

        if (conv_go) begin
            phase_next = PH_LIT;
            plm_next   = LM_NONE;
        end

        if (last) begin
            phase_next = PH_LIT;
            plm_next   = LM_NONE;
        end
    end

    always_comb begin
        logic   hit;
        event_t ce;

        hit  = 1'b0;
        ce   = conv_evt(ch, conv_lm, hit);
        push = star_push;
        evt  = '{kind: EV_DESC, arg_type: ARG_I32, len_mod: LM_NONE};

        if (conv_go) begin
            push = hit;
            evt  = ce;
        end

        if (last) begin
            push = 1'b1;
            evt  = '{kind: EV_FINAL, arg_type: ARG_I32, len_mod: LM_NONE};
        end

        push = push & accept;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_LIT;
            plm_reg   <= LM_NONE;
        end else if (accept) begin
            phase_reg <= phase_next;
            plm_reg   <= plm_next;
        end
    end

endmodule

// File: hw/rtl/fsac_queue.sv
// fsac_queue: small event fifo between the parser front and the result back
// uses fsac_pkg
module fsac_queue
    import fsac_pkg::*;
(
    input  logic   aclk,
    input  logic   aresetn,
    input  logic   push,
    input  event_t push_evt,
    output logic   full,
    input  logic   pop,
    output logic   head_valid,
    output event_t head_evt
);

    event_t               mem [QUEUE_DEPTH];
    logic [Q_PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [Q_PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [Q_CNT_W-1:0]   cnt_reg, cnt_next;
    logic                 do_pop;

    assign full       = (cnt_reg == Q_CNT_W'(QUEUE_DEPTH));
    assign head_valid = (cnt_reg != '0);
    assign head_evt   = mem[rd_ptr_reg];
    assign do_pop     = pop & head_valid;

    always_comb begin
        wr_ptr_next = push   ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        cnt_next    = cnt_reg + Q_CNT_W'(push) - Q_CNT_W'(do_pop);
    end

    always_ff @(posedge aclk) begin
        if (push) mem[wr_ptr_reg] <= push_evt;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

endmodule

// File: hw/rtl/fsac_back.sv
// fsac_back: descriptor numbering, limit and reject handling, output register
// uses fsac_pkg
module fsac_back
    import fsac_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 head_valid,
    input  event_t               head_evt,
    output logic                 pop,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_TDATA_W-1:0] m_tdata,   // arg_type, len_mod, op_index, op_total, status, pad
    output logic                 m_tlast    // is_final
);

    logic [CNT_W-1:0] cnt_reg, cnt_next;
    status_t          halt_reg, halt_next;
    logic             valid_reg, valid_next;
    logic             final_reg, final_next;
    arg_t             type_reg, type_next;
    lenmod_t          lm_reg, lm_next;
    logic [5:0]       idx_reg, idx_next;
    logic [6:0]       total_reg, total_next;
    status_t          stat_reg, stat_next;

    assign pop = head_valid & (~valid_reg | m_tready);

    always_comb begin
        cnt_next   = cnt_reg;
        halt_next  = halt_reg;
        valid_next = valid_reg & ~m_tready;
        final_next = final_reg;
        type_next  = type_reg;
        lm_next    = lm_reg;
        idx_next   = idx_reg;
        total_next = total_reg;
        stat_next  = stat_reg;
        if (pop) begin
            case (head_evt.kind)
                EV_FINAL: begin
                    valid_next = 1'b1;
                    final_next = 1'b1;
                    type_next  = ARG_I32;
                    lm_next    = LM_NONE;
                    idx_next   = '0;
                    total_next = cnt_reg[6:0];
                    stat_next  = halt_reg;
                    cnt_next   = '0;
                    halt_next  = ST_READY;
                end
                EV_DESC: begin
                    if (halt_reg == ST_READY) begin
                        if (cnt_reg >= CNT_W'(MAX_DESCRIPTORS)) begin
                            halt_next = ST_OVERFLOW;
                        end else begin
                            valid_next = 1'b1;
                            final_next = 1'b0;
                            type_next  = head_evt.arg_type;
                            lm_next    = head_evt.len_mod;
                            idx_next   = cnt_reg[5:0];
                            total_next = '0;
                            stat_next  = ST_READY;
                            cnt_next   = cnt_reg + 1'b1;
                        end
                    end
                end
                EV_REJECT: begin
                    if (halt_reg == ST_READY) halt_next = ST_REJECT;
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg   <= '0;
            halt_reg  <= ST_READY;
            valid_reg <= 1'b0;
        end else begin
            cnt_reg   <= cnt_next;
            halt_reg  <= halt_next;
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        final_reg <= final_next;
        type_reg  <= type_next;
        lm_reg    <= lm_next;
        idx_reg   <= idx_next;
        total_reg <= total_next;
        stat_reg  <= stat_next;
    end

    assign m_tvalid = valid_reg;
    assign m_tlast  = final_reg;
    assign m_tdata  = {1'b0, stat_reg, total_reg, idx_reg, lm_reg, type_reg};

endmodule

// File: hw/rtl/format_spec_argument_classifier_unit.sv
// format_spec_argument_classifier_unit: printf format string classifier top
// level, wires fsac_front, fsac_queue and fsac_back; uses fsac_pkg
//
// input channel s_*: one format character per request in s_tdata[7:0];
// s_tlast marks the terminator request, whose character is ignored
// output channel m_*: one argument descriptor per '*' or known conversion,
// and one final status request (m_tlast high) per terminator, carrying
// the descriptor total and status: ready, overflow, or rejected %n
// throughput: one character per cycle while the event queue is not full;
// the front parser decides each character in the cycle it is accepted and
// the back numbers descriptors one event per cycle while its output register
// is empty or taken; path: a result's event is written into the event queue
// at the edge that accepts the character that caused it, then into the
// output register that drives m_tvalid
// stall: the output register holds while m_tready is low; the four-entry
// event queue keeps taking characters until it fills, then s_tready drops
// reset: aresetn low at a clock edge returns the parser to literal text,
// clears the descriptor count and status and empties queue and output
module format_spec_argument_classifier_unit
    import fsac_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,   // ch
    input  logic                 s_tlast,   // terminator
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_TDATA_W-1:0] m_tdata,   // arg_type, len_mod, op_index, op_total, status, pad
    output logic                 m_tlast    // is_final
);

    logic   accept;
    logic   push;
    event_t push_evt;
    logic   full;
    logic   pop;
    logic   head_valid;
    event_t head_evt;

    assign s_tready = ~full;
    assign accept   = s_tvalid & s_tready;

    fsac_front u_front (
        .aclk    (aclk),
        .aresetn (aresetn),
        .accept  (accept),
        .ch      (s_tdata[7:0]),
        .last    (s_tlast),
        .push    (push),
        .evt     (push_evt)
    );

    fsac_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (push),
        .push_evt   (push_evt),
        .full       (full),
        .pop        (pop),
        .head_valid (head_valid),
        .head_evt   (head_evt)
    );

    fsac_back u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .head_valid (head_valid),
        .head_evt   (head_evt),
        .pop        (pop),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tlast    (m_tlast)
    );

endmodule
